FILE: design/aqs_pkg.sv
package aqs_pkg;

  localparam int QUAT_WIDTH = 32;
  localparam int QFRAC      = QUAT_WIDTH - 2;
  localparam int Q30_DN     = (QFRAC >= 30) ? QFRAC - 30 : 0;
  localparam int Q30_UP     = (QFRAC < 30) ? 30 - QFRAC : 0;
  localparam int INC_SHIFT  = 60 - QFRAC;
  localparam int CFG_IDX_W  = 2;

  localparam logic signed [30:0] HALF_RAD_Q40 = 31'sd599690565;
  localparam logic signed [26:0] DT_Q32       = 27'sd42949673;
  localparam logic signed [QUAT_WIDTH-1:0] Q_ONE = {2'b01, {QFRAC{1'b0}}};
  localparam logic signed [31:0] START_ONE = 32'sh4000_0000;

  localparam logic signed [63:0] S32_HI = 64'sd2147483647;
  localparam logic signed [63:0] S32_LO = -64'sd2147483648;
  localparam logic signed [63:0] SQ_HI  = (64'sd1 <<< (QUAT_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SQ_LO  = -SQ_HI - 64'sd1;

  typedef struct packed {
    logic               first_of_batch;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [15:0]        gain;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_qw;
    logic signed [31:0] out_qx;
    logic signed [31:0] out_qy;
    logic signed [31:0] out_qz;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_HG_MUL, OP_HG_SUM, OP_NRM_A, OP_NRM_C, OP_CR_MUL, OP_CR_SUM,
    OP_CM_MUL, OP_CM_SUM, OP_FB_MUL, OP_FB_SUM, OP_DT_MUL, OP_INC_MUL, OP_INC_SUM
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic accel_zero;
    logic dot_neg;
    logic cm_zero;
    logic nrm_done;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > S32_HI) return S32_HI[31:0];
    if (x < S32_LO) return S32_LO[31:0];
    return x[31:0];
  endfunction

  function automatic logic signed [QUAT_WIDTH-1:0] sat_q(input logic signed [63:0] x);
    if (x > SQ_HI) return SQ_HI[QUAT_WIDTH-1:0];
    if (x < SQ_LO) return SQ_LO[QUAT_WIDTH-1:0];
    return x[QUAT_WIDTH-1:0];
  endfunction

  function automatic logic signed [QUAT_WIDTH-1:0] to_state(input logic signed [31:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    t = (t >>> Q30_UP) <<< Q30_DN;
    return sat_q(t);
  endfunction

  function automatic logic signed [31:0] to_q30(input logic signed [QUAT_WIDTH-1:0] q);
    logic signed [63:0] t;
    t = 64'(q);
    t = (t >>> Q30_DN) <<< Q30_UP;
    return t[31:0];
  endfunction

endpackage

FILE: design/aqs_nrm.sv
module aqs_nrm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] val,
  input  logic [63:0]        den,
  output logic               done,
  output logic signed [33:0] res
);
  import aqs_pkg::*;

  localparam int DIV_STEPS  = 124;
  localparam int SQRT_STEPS = 32;

  typedef enum logic [1:0] {N_IDLE, N_SQ, N_DIV, N_SQRT} nstate_t;

  nstate_t     state_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic        neg_r;
  logic [31:0] mag_r;
  logic [63:0] den_r, dvd_r, rem_r, quo_r, n_r, root_r, bit_r;
  logic signed [33:0] res_r;

  logic [64:0] t;
  logic        ge;
  logic [63:0] rem_nxt, quo_nxt, sq_try, n_nxt, root_nxt;
  logic        sq_ge;
  logic [33:0] rmag;

  // long division step, then square root step
  always_comb begin
    t        = {rem_r, dvd_r[63]};
    ge       = t >= {1'b0, den_r};
    rem_nxt  = ge ? 64'(t - {1'b0, den_r}) : t[63:0];
    quo_nxt  = {quo_r[62:0], ge};
    sq_try   = root_r + bit_r;
    sq_ge    = n_r >= sq_try;
    n_nxt    = sq_ge ? n_r - sq_try : n_r;
    root_nxt = sq_ge ? (root_r >> 1) + bit_r : root_r >> 1;
    rmag     = {2'b00, root_nxt[31:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        N_IDLE: if (start) state_r <= N_SQ;
        N_SQ: begin
          cnt_r   <= '0;
          state_r <= N_DIV;
        end
        N_DIV: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(DIV_STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= N_SQRT;
          end
        end
        N_SQRT: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(SQRT_STEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= N_IDLE;
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE: if (start) begin
        neg_r <= val[31];
        mag_r <= val[31] ? 32'd0 - val : val;
        den_r <= den;
      end
      N_SQ: begin
        dvd_r <= 64'(mag_r) * 64'(mag_r);
        rem_r <= '0;
        quo_r <= '0;
      end
      N_DIV: begin
        dvd_r <= dvd_r << 1;
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        if (cnt_r == 7'(DIV_STEPS - 1)) begin
          n_r    <= quo_nxt;
          root_r <= '0;
          bit_r  <= 64'h4000_0000_0000_0000;
        end
      end
      N_SQRT: begin
        n_r    <= n_nxt;
        root_r <= root_nxt;
        bit_r  <= bit_r >> 2;
        if (cnt_r == 7'(SQRT_STEPS - 1)) res_r <= neg_r ? 34'd0 - rmag : rmag;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: design/aqs_ctrl.sv
module aqs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output aqs_pkg::dp_cmd_t  cmd,
  input  aqs_pkg::dp_stat_t stat
);
  import aqs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_HG_MUL, S_HG_SUM, S_NRM_A, S_NRM_A_WAIT, S_CR_MUL, S_CR_SUM, S_CM_MUL,
    S_CM_SUM, S_CHK, S_NRM_C, S_NRM_C_WAIT, S_FB_MUL, S_FB_SUM, S_DT_MUL, S_INC_MUL,
    S_INC_SUM
  } state_t;

  state_t     state_r;
  logic [1:0] idx_r;
  logic       out_valid_r;
  logic       out_hold;

  assign out_hold  = out_valid_r && out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.op  = OP_NONE;
    cmd.idx = idx_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) cmd.op = OP_LOAD;
      S_HG_MUL:  cmd.op = OP_HG_MUL;
      S_HG_SUM:  cmd.op = OP_HG_SUM;
      S_NRM_A:   cmd.op = OP_NRM_A;
      S_CR_MUL:  cmd.op = OP_CR_MUL;
      S_CR_SUM:  cmd.op = OP_CR_SUM;
      S_CM_MUL:  cmd.op = OP_CM_MUL;
      S_CM_SUM:  cmd.op = OP_CM_SUM;
      S_NRM_C:   cmd.op = OP_NRM_C;
      S_FB_MUL:  cmd.op = OP_FB_MUL;
      S_FB_SUM:  cmd.op = OP_FB_SUM;
      S_DT_MUL:  cmd.op = OP_DT_MUL;
      S_INC_MUL: cmd.op = OP_INC_MUL;
      S_INC_SUM: if (!out_hold) cmd.op = OP_INC_SUM;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_INC_SUM && !out_hold) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)    out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE:   if (in_valid) state_r <= S_HG_MUL;
        S_HG_MUL: state_r <= S_HG_SUM;
        S_HG_SUM: begin
          idx_r   <= '0;
          state_r <= stat.accel_zero ? S_FB_MUL : S_NRM_A;
        end
        S_NRM_A:  state_r <= S_NRM_A_WAIT;
        S_NRM_A_WAIT: if (stat.nrm_done) begin
          idx_r   <= idx_r + 2'd1;
          state_r <= (idx_r == 2'd2) ? S_CR_MUL : S_NRM_A;
        end
        S_CR_MUL: state_r <= S_CR_SUM;
        S_CR_SUM: state_r <= S_CM_MUL;
        S_CM_MUL: state_r <= S_CM_SUM;
        S_CM_SUM: state_r <= S_CHK;
        S_CHK: begin
          idx_r   <= '0;
          state_r <= (stat.dot_neg && !stat.cm_zero) ? S_NRM_C : S_FB_MUL;
        end
        S_NRM_C:  state_r <= S_NRM_C_WAIT;
        S_NRM_C_WAIT: if (stat.nrm_done) begin
          idx_r   <= idx_r + 2'd1;
          state_r <= (idx_r == 2'd2) ? S_FB_MUL : S_NRM_C;
        end
        S_FB_MUL:  state_r <= S_FB_SUM;
        S_FB_SUM:  state_r <= S_DT_MUL;
        S_DT_MUL:  state_r <= S_INC_MUL;
        S_INC_MUL: state_r <= S_INC_SUM;
        S_INC_SUM: if (!out_hold) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/aqs_dp.sv
module aqs_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [aqs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  aqs_pkg::in_item_t               in_data,
  input  aqs_pkg::dp_cmd_t                cmd,
  output aqs_pkg::dp_stat_t               stat,
  output aqs_pkg::out_item_t              out_data
);
  import aqs_pkg::*;

  logic signed [31:0]           st_r [4];
  logic signed [QUAT_WIDTH-1:0] rq_r [4];
  in_item_t                     in_r;
  logic signed [63:0]           hp_r [6];
  logic [31:0]                  asq_r [3];
  logic signed [31:0]           hg_r [3];
  logic [31:0]                  m_r;
  logic signed [31:0]           an_r [3];
  logic signed [63:0]           cp_r [9];
  logic signed [33:0]           c_r [3];
  logic                         dot_neg_r;
  logic [63:0]                  csq_r [3];
  logic [63:0]                  cm_r;
  logic signed [50:0]           fp_r [3];
  logic signed [46:0]           gp_r [3];
  logic signed [39:0]           h_r [3];
  logic signed [31:0]           d_r [3];
  logic signed [63:0]           ip_r [12];
  out_item_t                    out_r;
  logic                         tgt_c_r;
  logic [1:0]                   tgt_r;

  logic signed [15:0]           g [3];
  logic signed [15:0]           a [3];
  logic signed [31:0]           q30 [4];
  logic [31:0]                  cmag [3];
  logic signed [66:0]           dtp [3];
  logic signed [63:0]           dot_w;
  logic signed [63:0]           inc [4];
  logic signed [QUAT_WIDTH-1:0] nq [4];
  logic                         nrm_start, nrm_done;
  logic signed [31:0]           nrm_val;
  logic [63:0]                  nrm_den;
  logic signed [33:0]           nrm_res;

  assign g[0] = in_r.gyro_x;
  assign g[1] = in_r.gyro_y;
  assign g[2] = in_r.gyro_z;
  assign a[0] = in_r.accel_x;
  assign a[1] = in_r.accel_y;
  assign a[2] = in_r.accel_z;

  always_comb begin
    for (int k = 0; k < 4; k++) q30[k] = to_q30(rq_r[k]);
    for (int i = 0; i < 3; i++) begin
      cmag[i] = c_r[i][31] ? 32'd0 - c_r[i][31:0] : c_r[i][31:0];
      dtp[i]  = h_r[i] * DT_Q32;
    end
    dot_w  = cp_r[6] + cp_r[7] + cp_r[8];
    inc[0] = -ip_r[0] - ip_r[1] - ip_r[2];
    inc[1] = ip_r[3] + ip_r[4] - ip_r[5];
    inc[2] = ip_r[6] - ip_r[7] + ip_r[8];
    inc[3] = ip_r[9] + ip_r[10] - ip_r[11];
    for (int k = 0; k < 4; k++) nq[k] = sat_q(64'(rq_r[k]) + (inc[k] >>> INC_SHIFT));
  end

  assign nrm_start = (cmd.op == OP_NRM_A) || (cmd.op == OP_NRM_C);
  assign nrm_val   = (cmd.op == OP_NRM_C) ? c_r[cmd.idx][31:0] : 32'(a[cmd.idx]);
  assign nrm_den   = (cmd.op == OP_NRM_C) ? cm_r : {32'd0, m_r};

  aqs_nrm u_nrm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nrm_start),
    .val   (nrm_val),
    .den   (nrm_den),
    .done  (nrm_done),
    .res   (nrm_res)
  );

  // start registers and running quaternion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0] <= START_ONE;
      st_r[1] <= '0;
      st_r[2] <= '0;
      st_r[3] <= '0;
      rq_r[0] <= Q_ONE;
      rq_r[1] <= '0;
      rq_r[2] <= '0;
      rq_r[3] <= '0;
    end else begin
      if (cfg_we) st_r[cfg_index] <= cfg_wdata;
      if (cmd.op == OP_LOAD && in_data.first_of_batch) begin
        for (int k = 0; k < 4; k++) rq_r[k] <= to_state(st_r[k]);
      end
      if (cmd.op == OP_INC_SUM) begin
        for (int k = 0; k < 4; k++) rq_r[k] <= nq[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nrm_start) begin
      tgt_c_r <= cmd.op == OP_NRM_C;
      tgt_r   <= cmd.idx;
    end
    if (nrm_done) begin
      if (tgt_c_r) c_r[tgt_r] <= nrm_res;
      else         an_r[tgt_r] <= nrm_res[31:0];
    end
    unique case (cmd.op)
      OP_LOAD: in_r <= in_data;
      OP_HG_MUL: begin
        hp_r[0] <= st_r[1] * st_r[3];
        hp_r[1] <= st_r[0] * st_r[2];
        hp_r[2] <= st_r[2] * st_r[3];
        hp_r[3] <= st_r[0] * st_r[1];
        hp_r[4] <= st_r[0] * st_r[0];
        hp_r[5] <= st_r[3] * st_r[3];
        for (int i = 0; i < 3; i++) asq_r[i] <= 32'(a[i]) * 32'(a[i]);
      end
      OP_HG_SUM: begin
        hg_r[0] <= sat32((hp_r[0] >>> 30) - (hp_r[1] >>> 30));
        hg_r[1] <= sat32((hp_r[2] >>> 30) + (hp_r[3] >>> 30));
        hg_r[2] <= sat32((hp_r[4] >>> 30) + (hp_r[5] >>> 30) - 64'sd536870912);
        m_r     <= asq_r[0] + asq_r[1] + asq_r[2];
      end
      OP_CR_MUL: begin
        cp_r[0] <= an_r[1] * hg_r[2];
        cp_r[1] <= an_r[2] * hg_r[1];
        cp_r[2] <= an_r[2] * hg_r[0];
        cp_r[3] <= an_r[0] * hg_r[2];
        cp_r[4] <= an_r[0] * hg_r[1];
        cp_r[5] <= an_r[1] * hg_r[0];
        for (int i = 0; i < 3; i++) cp_r[6+i] <= an_r[i] * hg_r[i];
      end
      OP_CR_SUM: begin
        c_r[0]    <= 34'(sat32((cp_r[0] - cp_r[1]) >>> 30));
        c_r[1]    <= 34'(sat32((cp_r[2] - cp_r[3]) >>> 30));
        c_r[2]    <= 34'(sat32((cp_r[4] - cp_r[5]) >>> 30));
        dot_neg_r <= dot_w[63];
      end
      OP_CM_MUL: for (int i = 0; i < 3; i++) csq_r[i] <= 64'(cmag[i]) * 64'(cmag[i]);
      OP_CM_SUM: cm_r <= csq_r[0] + csq_r[1] + csq_r[2];
      OP_FB_MUL: begin
        for (int i = 0; i < 3; i++) begin
          fp_r[i] <= c_r[i] * $signed({1'b0, in_r.gain});
          gp_r[i] <= g[i] * HALF_RAD_Q40;
        end
      end
      OP_FB_SUM: begin
        for (int i = 0; i < 3; i++)
          h_r[i] <= 40'((gp_r[i] >>> 10) +
                        (stat.accel_zero ? 51'sd0 : (fp_r[i] >>> 12)));
      end
      OP_DT_MUL: for (int i = 0; i < 3; i++) d_r[i] <= dtp[i][63:32];
      OP_INC_MUL: begin
        ip_r[0]  <= q30[1] * d_r[0];
        ip_r[1]  <= q30[2] * d_r[1];
        ip_r[2]  <= q30[3] * d_r[2];
        ip_r[3]  <= q30[0] * d_r[0];
        ip_r[4]  <= q30[2] * d_r[2];
        ip_r[5]  <= q30[3] * d_r[1];
        ip_r[6]  <= q30[0] * d_r[1];
        ip_r[7]  <= q30[1] * d_r[2];
        ip_r[8]  <= q30[3] * d_r[0];
        ip_r[9]  <= q30[0] * d_r[2];
        ip_r[10] <= q30[1] * d_r[1];
        ip_r[11] <= q30[2] * d_r[0];
      end
      OP_INC_SUM: begin
        out_r.out_qw <= to_q30(nq[0]);
        out_r.out_qx <= to_q30(nq[1]);
        out_r.out_qy <= to_q30(nq[2]);
        out_r.out_qz <= to_q30(nq[3]);
      end
      default: ;
    endcase
  end

  assign stat.accel_zero = (in_r.accel_x == 16'sd0) && (in_r.accel_y == 16'sd0) &&
                           (in_r.accel_z == 16'sd0);
  assign stat.dot_neg    = dot_neg_r;
  assign stat.cm_zero    = cm_r == 64'd0;
  assign stat.nrm_done   = nrm_done;
  assign out_data        = out_r;

endmodule

FILE: design/ahrs_quaternion_step_core.sv
// one complementary-filter step per transfer: the running quaternion is advanced
// by the gyro rate plus gain-weighted accelerometer feedback, and the updated
// quaternion (q2.30, saturated) comes back as one result transfer. items are
// processed one at a time; each vector component passes through the shared
// bit-serial divide/square-root unit in turn. an item with zero acceleration skips
// that unit, and an item whose cross product is renormalized (negative dot
// product) goes through it once more per component. a finished result waits in
// the output register while the next item is already accepted; only a result
// still stalled when the following one is ready holds the block.
// first_of_batch reloads the running quaternion from the start registers, which
// also define the reference gravity direction; write them only while idle.
module ahrs_quaternion_step_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  aqs_pkg::in_item_t             in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output aqs_pkg::out_item_t            out_data,
  // start quaternion registers
  input  logic                          cfg_we,
  input  logic [aqs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import aqs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: walks the step through its phases
  aqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // arithmetic, state and normalization unit
  aqs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after input transfer");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_INC_SUM) |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // normalization never completes right after it is started
  a_nrm_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_NRM_A || cmd.op == OP_NRM_C) |=> !stat.nrm_done)
    else $error("normalization finished too early");

  // input is captured only on a transfer
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> (in_valid && !in_stall))
    else $error("load without input transfer");

endmodule
